// File: rtl/lkvc_pkg.sv
// Shared constants, types and control codes of the LRU key/value cache.
// No dependencies; used by lru_key_value_cache.
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W      = IDX_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 31;
  localparam int RD_W        = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_RESP
  } state_e;

endpackage

// File: rtl/lkvc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lkvc_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// Depends on lkvc_pkg and lkvc_ram (value store).
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------------
//   in      | in_valid_i / in_stall_o   | mode_i, key_i, value_i
//   out     | out_valid_o / out_stall_i | hit_o, read_value_o, evicted_o
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_capacity_i
//
// Per word: a key compare against all valid tags at accept, a recency-rank
// update and value RAM access in the update state, then the registered RAM
// read reaches the output register in the response state, where the next
// word can be accepted unless the output stalls.
// Reset clears valid marks, ranks and the count at once; no clearing pass.
// A stalled output holds the result and stalls the next word in its last cycle.
module lru_key_value_cache (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        mode_i,
  input  logic signed [lkvc_pkg::KEY_W-1:0] key_i,
  input  logic [lkvc_pkg::VAL_W-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic signed [lkvc_pkg::RD_W-1:0] read_value_o,
  output logic                        evicted_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_capacity_i
);

  localparam int N = lkvc_pkg::MAX_ENTRIES;

  function automatic lkvc_pkg::idx_t first_one(input logic [N-1:0] v);
    lkvc_pkg::idx_t idx;
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = lkvc_pkg::IDX_W'(i);
      end
    end
    return idx;
  endfunction

  lkvc_pkg::state_e state_q, state_d;

  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic [N-1:0]               valid_q, valid_d;
  lkvc_pkg::rank_t            rank_q [N];
  lkvc_pkg::rank_t            rank_d [N];
  lkvc_pkg::cnt_t             count_q, count_d;
  logic [lkvc_pkg::KEY_W-1:0] keys_q [N];

  // accepted word
  logic                       mode_q;
  logic [lkvc_pkg::KEY_W-1:0] key_q;
  logic [lkvc_pkg::VAL_W-1:0] value_q;
  logic [N-1:0]               hit_vec_q;
  logic [N-1:0]               hit_vec;

  // carried from the update cycle to the response cycle
  logic resp_mode_q, resp_hit_q, resp_evict_q;

  logic                       out_valid_q, out_valid_d;
  logic                       hit_q;
  logic [lkvc_pkg::RD_W-1:0]  read_value_q;
  logic                       evicted_q;

  logic in_fire, out_free, load_out, look;
  logic hit_any, full, set_miss;
  lkvc_pkg::idx_t  hit_idx, victim_idx, free_idx, ins_idx;
  lkvc_pkg::rank_t hit_rank, last_rank;
  lkvc_pkg::cnt_t  count_m1;
  logic [N-1:0]    victim_vec;
  logic            ram_we, ram_re;
  logic [lkvc_pkg::VAL_W-1:0] ram_rdata;
  lkvc_pkg::idx_t  ram_addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_capacity_i;
    end
  end

  // tag compare straight off the input port; state is current at accept
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_vec[i] = valid_q[i] && (keys_q[i] == key_i);
    end
  end

  // ---------------- control ----------------
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::S_IDLE: begin
        if (in_fire) state_d = lkvc_pkg::S_LOOK;
      end
      lkvc_pkg::S_LOOK: begin
        state_d = lkvc_pkg::S_RESP;
      end
      lkvc_pkg::S_RESP: begin
        if (out_free) state_d = in_fire ? lkvc_pkg::S_LOOK : lkvc_pkg::S_IDLE;
      end
      default: state_d = lkvc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    look       = 1'b0;
    unique case (state_q)
      lkvc_pkg::S_IDLE: in_stall_o = 1'b0;
      lkvc_pkg::S_LOOK: look = 1'b1;
      lkvc_pkg::S_RESP: begin
        in_stall_o = !out_free;
        load_out   = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  assign in_fire = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= mode_i;
      key_q     <= key_i;
      value_q   <= value_i;
      hit_vec_q <= hit_vec;
    end
  end

  // ---------------- update cycle ----------------
  assign hit_any  = |hit_vec_q;
  assign hit_idx  = first_one(hit_vec_q);
  assign hit_rank = rank_q[hit_idx];
  assign set_miss = (mode_q == lkvc_pkg::MODE_SET) && !hit_any;

  // capacity zero acts as one, anything above the table size saturates
  always_comb begin
    if (cap_q == '0) begin
      full = lkvc_pkg::cmp_t'(count_q) >= lkvc_pkg::cmp_t'(1);
    end else if (lkvc_pkg::cmp_t'(cap_q) > lkvc_pkg::cmp_t'(N)) begin
      full = lkvc_pkg::cmp_t'(count_q) >= lkvc_pkg::cmp_t'(N);
    end else begin
      full = lkvc_pkg::cmp_t'(count_q) >= lkvc_pkg::cmp_t'(cap_q);
    end
  end

  // ranks of valid entries are always 0..count-1, so the oldest is count-1
  assign count_m1  = count_q - lkvc_pkg::cnt_t'(1);
  assign last_rank = count_m1[lkvc_pkg::RANK_W-1:0];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      victim_vec[i] = valid_q[i] && (rank_q[i] == last_rank);
    end
  end

  assign victim_idx = first_one(victim_vec);
  assign free_idx   = first_one(~valid_q);
  assign ins_idx    = full ? victim_idx : free_idx;

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < N; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (look) begin
      if (hit_any) begin
        for (int i = 0; i < N; i++) begin
          if (i == int'(hit_idx)) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + lkvc_pkg::rank_t'(1);
          end
        end
      end else if (set_miss) begin
        // age everything else; when full, the victim slot is reused in place
        for (int i = 0; i < N; i++) begin
          if ((i != int'(ins_idx)) && valid_q[i]) begin
            rank_d[i] = rank_q[i] + lkvc_pkg::rank_t'(1);
          end
        end
        rank_d[ins_idx]  = '0;
        valid_d[ins_idx] = 1'b1;
        if (!full) count_d = count_q + lkvc_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (look && set_miss) begin
      keys_q[ins_idx] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_mode_q  <= lkvc_pkg::MODE_GET;
      resp_hit_q   <= 1'b0;
      resp_evict_q <= 1'b0;
    end else if (look) begin
      resp_mode_q  <= mode_q;
      resp_hit_q   <= hit_any;
      resp_evict_q <= set_miss && full;
    end
  end

  // ---------------- value store ----------------
  assign ram_we   = look && (mode_q == lkvc_pkg::MODE_SET);
  assign ram_re   = look && (mode_q == lkvc_pkg::MODE_GET) && hit_any;
  assign ram_addr = hit_any ? hit_idx : ins_idx;

  lkvc_ram #(
    .WIDTH (lkvc_pkg::VAL_W),
    .DEPTH (N)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (value_q),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------- output register ----------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      hit_q     <= resp_hit_q;
      evicted_q <= resp_evict_q;
      if (resp_mode_q == lkvc_pkg::MODE_SET) begin
        read_value_q <= '0;
      end else if (resp_hit_q) begin
        read_value_q <= {1'b0, ram_rdata};
      end else begin
        read_value_q <= '1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = read_value_q;
  assign evicted_o    = evicted_q;

  // ---------------- checks ----------------
  a_tag_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::S_LOOK) |-> $onehot0(hit_vec_q))
    else $error("more than one valid entry matches the key");

  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count disagrees with valid marks");

  a_victim_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (look && set_miss && full) |-> $onehot(victim_vec))
    else $error("no single oldest entry on eviction");

  a_free_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (look && set_miss && !full) |-> !(&valid_q))
    else $error("insert without a free slot");

  a_look_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lkvc_pkg::S_LOOK) |=> (state_q == lkvc_pkg::S_RESP))
    else $error("update cycle not followed by response");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for lru_key_value_cache: drives get/set words,
// predicts hit, read value and eviction with an LRU shadow of the store.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic                      hit;
    logic [lkvc_pkg::RD_W-1:0] read_value;
    logic                      evicted;
  } cache_reply_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       mode_i = lkvc_pkg::MODE_GET;
  logic [lkvc_pkg::KEY_W-1:0] key_i = '0;
  logic [lkvc_pkg::VAL_W-1:0] value_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       hit_o;
  logic [lkvc_pkg::RD_W-1:0]  read_value_o;
  logic                       evicted_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [lkvc_pkg::CAP_W-1:0] cfg_capacity_i = '0;

  // shadow copy of the store and its recency order
  logic [lkvc_pkg::KEY_W-1:0] shadow_key [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] shadow_value [lkvc_pkg::MAX_ENTRIES];
  bit                         shadow_valid [lkvc_pkg::MAX_ENTRIES];
  int unsigned                shadow_rank [lkvc_pkg::MAX_ENTRIES];
  int unsigned                shadow_count = 0;
  logic [lkvc_pkg::CAP_W-1:0] shadow_capacity = lkvc_pkg::CAP_RESET;

  cache_reply_t               expected_replies [$];
  logic [lkvc_pkg::KEY_W-1:0] key_pool [32];

  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  int                  hold_len = 0;
  bit                  idle_on = 1'b0;
  int                  words_sent = 0;
  int                  gets_sent = 0;
  int                  hits_seen = 0;
  int                  evictions_seen = 0;
  int                  settings_used = 0;

  lru_key_value_cache u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .read_value_o   (read_value_o),
    .evicted_o      (evicted_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_replies.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Make one slot the newest: valid entries younger than the limit age by one.
  function automatic void make_newest(int slot, int unsigned limit);
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
      if (i != slot && shadow_valid[i] && shadow_rank[i] < limit)
        shadow_rank[i] = shadow_rank[i] + 1;
    end
    shadow_rank[slot] = 0;
  endfunction

  function automatic cache_reply_t lru_lookup_update(logic mode,
                                                     logic [lkvc_pkg::KEY_W-1:0] key,
                                                     logic [lkvc_pkg::VAL_W-1:0] value);
    cache_reply_t reply;
    int           slot;
    bit           found;
    bit           got;
    int unsigned  oldest;
    int unsigned  eff_cap;
    reply = '0;
    slot = 0;
    found = 1'b0;
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
      if (!found && shadow_valid[i] && shadow_key[i] == key) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      reply.hit = 1'b1;
      if (mode == lkvc_pkg::MODE_GET) reply.read_value = {1'b0, shadow_value[slot]};
      else shadow_value[slot] = value;
      make_newest(slot, shadow_rank[slot]);
    end else if (mode == lkvc_pkg::MODE_GET) begin
      reply.read_value = '1;
    end else begin
      eff_cap = (shadow_capacity == 0) ? 1 :
                (shadow_capacity > lkvc_pkg::MAX_ENTRIES) ? lkvc_pkg::MAX_ENTRIES :
                shadow_capacity;
      if (shadow_count >= eff_cap) begin
        got = 1'b0;
        oldest = 0;
        for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
          if (shadow_valid[i] && (!got || shadow_rank[i] > oldest)) begin
            got = 1'b1;
            oldest = shadow_rank[i];
            slot = i;
          end
        end
        if (got) begin
          reply.evicted = 1'b1;
          shadow_valid[slot] = 1'b0;
          shadow_count = shadow_count - 1;
        end
      end else begin
        for (int i = lkvc_pkg::MAX_ENTRIES - 1; i >= 0; i--)
          if (!shadow_valid[i]) slot = i;
      end
      if (!shadow_valid[slot]) begin
        shadow_key[slot] = key;
        shadow_value[slot] = value;
        shadow_valid[slot] = 1'b1;
        shadow_rank[slot] = 0;
        shadow_count = shadow_count + 1;
        make_newest(slot, 32'hFFFF_FFFF);
      end
    end
    return reply;
  endfunction

  task automatic report_mismatch(string field, logic [lkvc_pkg::RD_W-1:0] got,
                                 logic [lkvc_pkg::RD_W-1:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
  endtask

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    cache_reply_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected word", read_value_o, '0);
      end else begin
        want = expected_replies.pop_front();
        if (hit_o !== want.hit)
          report_mismatch("hit", lkvc_pkg::RD_W'(hit_o), lkvc_pkg::RD_W'(want.hit));
        if (read_value_o !== want.read_value)
          report_mismatch("read_value", read_value_o, want.read_value);
        if (evicted_o !== want.evicted)
          report_mismatch("evicted", lkvc_pkg::RD_W'(evicted_o),
                          lkvc_pkg::RD_W'(want.evicted));
      end
    end
  end

  // Output stall: random bursts, or one long hold when requested.
  initial begin : out_stall_gen
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(logic mode, logic [lkvc_pkg::KEY_W-1:0] key,
                           logic [lkvc_pkg::VAL_W-1:0] value);
    cache_reply_t reply;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    key_i <= key;
    value_i <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    reply = lru_lookup_update(mode, key, value);
    expected_replies.push_back(reply);
    words_sent++;
    if (mode == lkvc_pkg::MODE_GET) gets_sent++;
    if (reply.hit) hits_seen++;
    if (reply.evicted) evictions_seen++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] capacity);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_capacity_i <= capacity;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    shadow_capacity = capacity;
    settings_used++;
  endtask

  task automatic fill_key_pool();
    for (int i = 0; i < 32; i++) key_pool[i] = $urandom();
  endtask

  task automatic test_basic_access();
    send_word(lkvc_pkg::MODE_GET, 32'h8000_0000, 31'h0);
    send_word(lkvc_pkg::MODE_SET, 32'h8000_0000, 31'h7FFF_FFFF);
    send_word(lkvc_pkg::MODE_SET, 32'h7FFF_FFFF, 31'h0);
    send_word(lkvc_pkg::MODE_SET, 32'hFFFF_FFFF, 31'h2AAA_AAAA);
    send_word(lkvc_pkg::MODE_SET, 32'h0000_0000, 31'h5555_5555);
    send_word(lkvc_pkg::MODE_GET, 32'h8000_0000, 31'h7FFF_FFFF);
    send_word(lkvc_pkg::MODE_GET, 32'h7FFF_FFFF, 31'h1);
    send_word(lkvc_pkg::MODE_SET, 32'hFFFF_FFFF, 31'h1);
    send_word(lkvc_pkg::MODE_GET, 32'hFFFF_FFFF, 31'h0);
  endtask

  task automatic test_capacity_edges();
    // lower below the current count: one eviction per set miss
    write_capacity(lkvc_pkg::CAP_W'(2));
    send_word(lkvc_pkg::MODE_SET, 32'h0000_0011, 31'h11);
    send_word(lkvc_pkg::MODE_GET, 32'h0000_0000, 31'h0);
    send_word(lkvc_pkg::MODE_SET, 32'h0000_0012, 31'h12);
    // zero acts as one
    write_capacity(lkvc_pkg::CAP_W'(0));
    send_word(lkvc_pkg::MODE_SET, 32'h0000_0022, 31'h22);
    send_word(lkvc_pkg::MODE_SET, 32'h0000_0022, 31'h23);
    send_word(lkvc_pkg::MODE_GET, 32'h0000_0022, 31'h0);
    // above the table size saturates
    write_capacity(lkvc_pkg::CAP_W'(31));
    send_word(lkvc_pkg::MODE_SET, 32'h0000_0033, 31'h33);
    send_word(lkvc_pkg::MODE_SET, 32'h0000_0044, 31'h44);
    write_capacity(lkvc_pkg::CAP_W'(17));
    send_word(lkvc_pkg::MODE_GET, 32'h0000_0033, 31'h0);
    send_word(lkvc_pkg::MODE_SET, 32'h0000_0055, 31'h55);
  endtask

  task automatic run_random_words(int count);
    int                         pool_size;
    logic [lkvc_pkg::KEY_W-1:0] key;
    pool_size = (shadow_capacity == 0) ? 4 :
                (shadow_capacity > lkvc_pkg::MAX_ENTRIES) ? lkvc_pkg::MAX_ENTRIES + 4 :
                shadow_capacity + 3;
    fill_key_pool();
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) key = $urandom();
      else key = key_pool[$urandom_range(0, pool_size - 1)];
      send_word(1'($urandom_range(0, 1)), key, lkvc_pkg::VAL_W'($urandom()));
    end
  endtask

  task automatic test_random_mix();
    logic [lkvc_pkg::CAP_W-1:0] caps [8];
    caps = '{lkvc_pkg::CAP_W'(1), lkvc_pkg::CAP_W'(3), lkvc_pkg::CAP_W'(8),
             lkvc_pkg::CAP_W'(16), lkvc_pkg::CAP_W'(17), lkvc_pkg::CAP_W'(31),
             lkvc_pkg::CAP_W'(0), lkvc_pkg::CAP_W'($urandom_range(1, 15))};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      idle_on = (i % 3 != 2);
      run_random_words(160);
    end
  endtask

  // Hold the output long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    write_capacity(lkvc_pkg::CAP_W'(6));
    idle_on = 1'b0;
    hold_len = 80;
    run_random_words(30);
  endtask

  task automatic test_quiet_tail();
    write_capacity(lkvc_pkg::CAP_W'(lkvc_pkg::MAX_ENTRIES));
    idle_on = 1'b0;
    run_random_words(120);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;
    test_basic_access();
    test_capacity_edges();
    test_random_mix();
    test_backpressure();
    test_quiet_tail();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d words (%0d gets), %0d hits, %0d evictions", words_sent, gets_sent,
             hits_seen, evictions_seen);
    $display("over %0d capacity writes incl. zero, one, full and saturated; %0d mismatches",
             settings_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
